// File: rtl/whp_pkg.sv
// Shared types, constants and helper functions for the WAV header parser.
package whp_pkg;

    localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE       = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT        = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA       = 32'h6174_6164;
    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [15:0] PCM_FORMAT     = 16'd1;

    localparam int OFFSET_WIDTH = 6;

    localparam logic [OFFSET_WIDTH-1:0] OFF_RIFF      = 6'd3;
    localparam logic [OFFSET_WIDTH-1:0] OFF_WAVE      = 6'd11;
    localparam logic [OFFSET_WIDTH-1:0] OFF_FMT       = 6'd15;
    localparam logic [OFFSET_WIDTH-1:0] OFF_FMT_SIZE  = 6'd19;
    localparam logic [OFFSET_WIDTH-1:0] OFF_AUDIO_FMT = 6'd21;
    localparam logic [OFFSET_WIDTH-1:0] OFF_CHANNELS  = 6'd23;
    localparam logic [OFFSET_WIDTH-1:0] OFF_RATE      = 6'd27;
    localparam logic [OFFSET_WIDTH-1:0] OFF_BITS      = 6'd35;
    localparam logic [OFFSET_WIDTH-1:0] OFF_DATA      = 6'd39;
    localparam logic [OFFSET_WIDTH-1:0] OFF_LAST      = 6'd43;

    localparam int TDATA_IN_WIDTH  = 8;
    localparam int TDATA_OUT_WIDTH = 80;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_RIFF_WAVE = 2'd0,
        ERR_FMT_DATA  = 2'd1,
        ERR_NOT_PCM   = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        FMT_MONO8       = 3'd0,
        FMT_MONO16      = 3'd1,
        FMT_STEREO8     = 3'd2,
        FMT_STEREO16    = 3'd3,
        FMT_UNSUPPORTED = 3'd4
    } audio_fmt_t;

    typedef struct packed {
        kind_t      kind;
        err_t       error_code;
        audio_fmt_t audio_format;
        logic [31:0] sample_rate;
        logic [31:0] payload_size;
        logic [7:0]  payload_byte;
        logic        last;
    } result_t;

    function automatic audio_fmt_t format_code(input logic [15:0] channels,
                                               input logic [15:0] bits);
        audio_fmt_t code;
        code = FMT_UNSUPPORTED;
        if (channels == 16'd1 && bits == 16'd8) begin
            code = FMT_MONO8;
        end else if (channels == 16'd1 && bits == 16'd16) begin
            code = FMT_MONO16;
        end else if (channels == 16'd2 && bits == 16'd8) begin
            code = FMT_STEREO8;
        end else if (channels == 16'd2 && bits == 16'd16) begin
            code = FMT_STEREO16;
        end
        return code;
    endfunction

endpackage

// File: rtl/whp_core.sv
// Header field collector, tag checker and payload counter for the WAV parser.
module whp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       in_byte,
    input  logic             first_byte,
    output logic             res_valid,
    output whp_pkg::result_t res
);

    whp_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [whp_pkg::OFFSET_WIDTH-1:0] offset_reg, offset_next, offset_eff;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] channels_reg, channels_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] left_reg, left_next;
    logic [15:0] hi16;

    assign phase_eff  = first_byte ? whp_pkg::PH_HEADER : phase_reg;
    assign offset_eff = first_byte ? '0 : offset_reg;
    assign shift_next = first_byte ? {in_byte, 24'h0} : {in_byte, shift_reg[31:8]};
    assign hi16       = shift_next[31:16];

    always_comb begin
        phase_next    = phase_eff;
        offset_next   = offset_reg;
        channels_next = channels_reg;
        bits_next     = bits_reg;
        rate_next     = rate_reg;
        left_next     = left_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.kind      = whp_pkg::KIND_HEADER;
        res.error_code   = whp_pkg::ERR_RIFF_WAVE;
        res.audio_format = whp_pkg::FMT_MONO8;
        unique case (phase_eff)
            whp_pkg::PH_PAYLOAD: begin
                res_valid        = 1'b1;
                res.kind         = whp_pkg::KIND_PAYLOAD;
                res.payload_byte = in_byte;
                left_next        = left_reg - 32'd1;
                if (left_reg == 32'd1) begin
                    res.last   = 1'b1;
                    phase_next = whp_pkg::PH_IDLE;
                end
            end
            whp_pkg::PH_HEADER: begin
                offset_next = offset_eff + 6'd1;
                case (offset_eff)
                    whp_pkg::OFF_RIFF: begin
                        if (shift_next != whp_pkg::TAG_RIFF) begin
                            res_valid      = 1'b1;
                            res.kind       = whp_pkg::KIND_ERROR;
                            res.error_code = whp_pkg::ERR_RIFF_WAVE;
                            phase_next     = whp_pkg::PH_IDLE;
                        end
                    end
                    whp_pkg::OFF_WAVE: begin
                        if (shift_next != whp_pkg::TAG_WAVE) begin
                            res_valid      = 1'b1;
                            res.kind       = whp_pkg::KIND_ERROR;
                            res.error_code = whp_pkg::ERR_RIFF_WAVE;
                            phase_next     = whp_pkg::PH_IDLE;
                        end
                    end
                    whp_pkg::OFF_FMT: begin
                        if (shift_next != whp_pkg::TAG_FMT) begin
                            res_valid      = 1'b1;
                            res.kind       = whp_pkg::KIND_ERROR;
                            res.error_code = whp_pkg::ERR_FMT_DATA;
                            phase_next     = whp_pkg::PH_IDLE;
                        end
                    end
                    whp_pkg::OFF_FMT_SIZE: begin
                        if (shift_next != whp_pkg::FMT_CHUNK_SIZE) begin
                            res_valid      = 1'b1;
                            res.kind       = whp_pkg::KIND_ERROR;
                            res.error_code = whp_pkg::ERR_NOT_PCM;
                            phase_next     = whp_pkg::PH_IDLE;
                        end
                    end
                    whp_pkg::OFF_AUDIO_FMT: begin
                        if (hi16 != whp_pkg::PCM_FORMAT) begin
                            res_valid      = 1'b1;
                            res.kind       = whp_pkg::KIND_ERROR;
                            res.error_code = whp_pkg::ERR_NOT_PCM;
                            phase_next     = whp_pkg::PH_IDLE;
                        end
                    end
                    whp_pkg::OFF_CHANNELS: channels_next = hi16;
                    whp_pkg::OFF_RATE:     rate_next     = shift_next;
                    whp_pkg::OFF_BITS:     bits_next     = hi16;
                    whp_pkg::OFF_DATA: begin
                        if (shift_next != whp_pkg::TAG_DATA) begin
                            res_valid      = 1'b1;
                            res.kind       = whp_pkg::KIND_ERROR;
                            res.error_code = whp_pkg::ERR_FMT_DATA;
                            phase_next     = whp_pkg::PH_IDLE;
                        end
                    end
                    whp_pkg::OFF_LAST: begin
                        res_valid        = 1'b1;
                        res.kind         = whp_pkg::KIND_HEADER;
                        res.audio_format = whp_pkg::format_code(channels_reg, bits_reg);
                        res.sample_rate  = rate_reg;
                        res.payload_size = shift_next;
                        left_next        = shift_next;
                        phase_next       = (shift_next == 32'd0) ? whp_pkg::PH_IDLE
                                                                 : whp_pkg::PH_PAYLOAD;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= whp_pkg::PH_IDLE;
            offset_reg   <= '0;
            shift_reg    <= '0;
            channels_reg <= '0;
            bits_reg     <= '0;
            rate_reg     <= '0;
            left_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            channels_reg <= channels_next;
            bits_reg     <= bits_next;
            rate_reg     <= rate_next;
            left_reg     <= left_next;
            if (phase_eff == whp_pkg::PH_HEADER) begin
                offset_reg <= offset_next;
                shift_reg  <= shift_next;
            end
        end
    end

endmodule

// File: rtl/whp_out_reg.sv
// Result register that holds one result beat until the downstream side takes it.
module whp_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  logic             res_valid,
    input  whp_pkg::result_t res,
    input  logic             m_tready,
    output logic             m_tvalid,
    output whp_pkg::result_t m_res
);

    logic             valid_reg, valid_next;
    whp_pkg::result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// File: rtl/wav_header_parser_top.sv
// Top level of the canonical RIFF/WAVE PCM header parser.
// The parser takes a WAV file one byte per beat, with s_tuser high on the first byte of a
// file, checks the fixed 44-byte PCM header and emits one header beat, then passes exactly
// the data-size payload bytes with m_tlast on the final one; a failed check emits one error
// beat and later bytes are dropped until the next first byte. It takes one byte per clock
// while the result register is empty or being taken: each byte passes an input register,
// the combinational offset compare and shift logic, and a result register that presents
// it on the master side. Without backpressure the rate is one byte per clock, and only
// m_tready low can stall the input.
module wav_header_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [whp_pkg::TDATA_IN_WIDTH-1:0]  s_tdata,  // [7:0] in_byte
    input  logic        s_tuser,                          // [0] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] error_code, [4:2] audio_format, [36:5] sample_rate,
    // [68:37] payload_size, [76:69] payload_byte, [79:77] zero
    output logic [whp_pkg::TDATA_OUT_WIDTH-1:0] m_tdata,
    output logic [1:0]  m_tuser,                          // [1:0] kind
    output logic        m_tlast
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_first_reg;
    logic             advance;
    logic             res_valid;
    whp_pkg::result_t res;
    whp_pkg::result_t m_res;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata[7:0];
            in_first_reg <= s_tuser;
        end
    end

    whp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .in_byte    (in_byte_reg),
        .first_byte (in_first_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    whp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_res     (m_res)
    );

    assign m_tdata = {3'b000, m_res.payload_byte, m_res.payload_size, m_res.sample_rate,
                      m_res.audio_format, m_res.error_code};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule

// File: tb/sv/wav_header_parser_top_tb.sv
// Self-checking testbench for the WAV header parser: random files against a byte-level predictor.
`timescale 1ns / 100ps

module wav_header_parser_top_tb;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1600;
    localparam int HOLD_START   = 2500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS   = 2_000_000;

    typedef enum int {
        WAV_GOOD,
        WAV_BAD_RIFF,
        WAV_BAD_WAVE,
        WAV_BAD_FMT_TAG,
        WAV_BAD_FMT_SIZE,
        WAV_NOT_PCM,
        WAV_BAD_DATA_TAG,
        WAV_CUT_SHORT
    } wav_variant_t;

    typedef struct {
        logic [7:0] value;
        logic       first;
    } stream_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [whp_pkg::TDATA_IN_WIDTH-1:0] s_tdata = '0;   // [7:0] in_byte
    logic        s_tuser = 1'b0;                        // [0] first_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [1:0] error_code, [4:2] audio_format, [36:5] sample_rate,
    // [68:37] payload_size, [76:69] payload_byte, [79:77] zero
    logic [whp_pkg::TDATA_OUT_WIDTH-1:0] m_tdata;
    logic [1:0]  m_tuser;                               // [1:0] kind
    logic        m_tlast;

    stream_byte_t     pending_bytes[$];
    stream_byte_t     next_byte;
    whp_pkg::result_t expected_results[$];
    whp_pkg::result_t want;
    logic [7:0]       hdr_bytes [0:43];

    whp_pkg::phase_t parse_phase = whp_pkg::PH_IDLE;
    logic [5:0]  hdr_offset = '0;
    logic [31:0] shift_word = '0;
    logic [15:0] chan_count = '0;
    logic [15:0] bits_count = '0;
    logic [31:0] rate_word = '0;
    logic [31:0] remaining = '0;

    int          mismatch_count = 0;
    int          tx_wait = 0;
    int          rx_wait = 0;
    logic [31:0] cycle_count = '0;
    logic        hold_off = 1'b0;
    logic        tx_steady;
    logic        rx_steady;

    wav_header_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #TIMEOUT_NS;
        $display("== FAIL ==");
        $finish;
    end

    function automatic whp_pkg::audio_fmt_t classify_format(input logic [15:0] ch,
                                                            input logic [15:0] bits);
        case ({ch, bits})
            {16'd1, 16'd8}:  return whp_pkg::FMT_MONO8;
            {16'd1, 16'd16}: return whp_pkg::FMT_MONO16;
            {16'd2, 16'd8}:  return whp_pkg::FMT_STEREO8;
            {16'd2, 16'd16}: return whp_pkg::FMT_STEREO16;
            default:         return whp_pkg::FMT_UNSUPPORTED;
        endcase
    endfunction

    // Advances the expected parser state by one accepted byte.
    task automatic parse_byte(input logic [7:0] b, input logic first);
        whp_pkg::result_t res;
        logic [5:0]       off;
        logic [15:0]      upper;
        logic             failed;
        whp_pkg::err_t    code;
        begin
            res = '0;
            failed = 1'b0;
            code = whp_pkg::ERR_RIFF_WAVE;
            if (first) begin
                parse_phase = whp_pkg::PH_HEADER;
                hdr_offset = '0;
                shift_word = '0;
            end
            if (parse_phase == whp_pkg::PH_PAYLOAD) begin
                res.kind = whp_pkg::KIND_PAYLOAD;
                res.payload_byte = b;
                remaining = remaining - 32'd1;
                if (remaining == 32'd0) begin
                    res.last = 1'b1;
                    parse_phase = whp_pkg::PH_IDLE;
                end
                expected_results.push_back(res);
            end else if (parse_phase == whp_pkg::PH_HEADER) begin
                shift_word = {b, shift_word[31:8]};
                off = hdr_offset;
                hdr_offset = hdr_offset + 6'd1;
                upper = shift_word[31:16];
                case (off)
                    whp_pkg::OFF_RIFF: begin
                        failed = (shift_word != whp_pkg::TAG_RIFF);
                        code = whp_pkg::ERR_RIFF_WAVE;
                    end
                    whp_pkg::OFF_WAVE: begin
                        failed = (shift_word != whp_pkg::TAG_WAVE);
                        code = whp_pkg::ERR_RIFF_WAVE;
                    end
                    whp_pkg::OFF_FMT: begin
                        failed = (shift_word != whp_pkg::TAG_FMT);
                        code = whp_pkg::ERR_FMT_DATA;
                    end
                    whp_pkg::OFF_FMT_SIZE: begin
                        failed = (shift_word != whp_pkg::FMT_CHUNK_SIZE);
                        code = whp_pkg::ERR_NOT_PCM;
                    end
                    whp_pkg::OFF_AUDIO_FMT: begin
                        failed = (upper != whp_pkg::PCM_FORMAT);
                        code = whp_pkg::ERR_NOT_PCM;
                    end
                    whp_pkg::OFF_CHANNELS: chan_count = upper;
                    whp_pkg::OFF_RATE:     rate_word = shift_word;
                    whp_pkg::OFF_BITS:     bits_count = upper;
                    whp_pkg::OFF_DATA: begin
                        failed = (shift_word != whp_pkg::TAG_DATA);
                        code = whp_pkg::ERR_FMT_DATA;
                    end
                    whp_pkg::OFF_LAST: begin
                        remaining = shift_word;
                        res.kind = whp_pkg::KIND_HEADER;
                        res.audio_format = classify_format(chan_count, bits_count);
                        res.sample_rate = rate_word;
                        res.payload_size = shift_word;
                        parse_phase = (shift_word == 32'd0) ? whp_pkg::PH_IDLE
                                                            : whp_pkg::PH_PAYLOAD;
                        expected_results.push_back(res);
                    end
                    default: ;
                endcase
                if (failed) begin
                    res.kind = whp_pkg::KIND_ERROR;
                    res.error_code = code;
                    parse_phase = whp_pkg::PH_IDLE;
                    expected_results.push_back(res);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_value);
        if (got !== exp_value) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp_value));
        end
    endtask

    function automatic int draw_wait(input logic steady);
        if (steady || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic push_byte(input logic [7:0] value, input logic first);
        stream_byte_t item;
        begin
            item.value = value;
            item.first = first;
            pending_bytes.push_back(item);
        end
    endtask

    function automatic void put_le(input int pos, input logic [31:0] value, input int count);
        for (int i = 0; i < count; i++) begin
            hdr_bytes[pos + i] = value[8*i +: 8];
        end
    endfunction

    // Queues one file: a canonical header with random fields, optionally damaged, then payload.
    task automatic add_file(input wav_variant_t variant, input bit zero_size);
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] size;
        int          corrupt_at;
        int          sent;
        int          payload_count;
        begin
            case ($urandom_range(0, 9))
                8:       chans = 16'($urandom_range(0, 3));
                9:       chans = 16'($urandom);
                default: chans = 16'($urandom_range(1, 2));
            endcase
            case ($urandom_range(0, 9))
                8:       bits = ($urandom_range(0, 1) == 0) ? 16'd24 : 16'd0;
                9:       bits = 16'($urandom);
                default: bits = ($urandom_range(0, 1) == 0) ? 16'd8 : 16'd16;
            endcase
            case ($urandom_range(0, 3))
                0:       rate = 32'd44100;
                1:       rate = 32'd48000;
                default: rate = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       size = 32'd0;
                1:       size = $urandom;
                2:       size = 32'hFFFF_FFFF;
                default: size = $urandom_range(1, 24);
            endcase
            if (zero_size) begin
                size = 32'd0;
            end

            put_le(0, whp_pkg::TAG_RIFF, 4);
            put_le(4, $urandom, 4);
            put_le(8, whp_pkg::TAG_WAVE, 4);
            put_le(12, whp_pkg::TAG_FMT, 4);
            put_le(16, whp_pkg::FMT_CHUNK_SIZE, 4);
            put_le(20, 32'(whp_pkg::PCM_FORMAT), 2);
            put_le(22, 32'(chans), 2);
            put_le(24, rate, 4);
            put_le(28, $urandom, 4);
            put_le(32, $urandom, 2);
            put_le(34, 32'(bits), 2);
            put_le(36, whp_pkg::TAG_DATA, 4);
            put_le(40, size, 4);

            case (variant)
                WAV_BAD_RIFF:     corrupt_at = $urandom_range(0, 3);
                WAV_BAD_WAVE:     corrupt_at = $urandom_range(8, 11);
                WAV_BAD_FMT_TAG:  corrupt_at = $urandom_range(12, 15);
                WAV_BAD_FMT_SIZE: corrupt_at = $urandom_range(16, 19);
                WAV_NOT_PCM:      corrupt_at = $urandom_range(20, 21);
                WAV_BAD_DATA_TAG: corrupt_at = $urandom_range(36, 39);
                default:          corrupt_at = -1;
            endcase
            if (corrupt_at >= 0) begin
                hdr_bytes[corrupt_at] = hdr_bytes[corrupt_at] ^ 8'($urandom_range(1, 255));
            end

            sent = (variant == WAV_CUT_SHORT) ? $urandom_range(1, 43) : 44;
            for (int i = 0; i < sent; i++) begin
                push_byte(hdr_bytes[i], i == 0);
            end

            if (variant == WAV_GOOD) begin
                payload_count = (size > 64) ? $urandom_range(0, 30) : int'(size);
                if (size <= 64 && $urandom_range(0, 3) == 0) begin
                    payload_count = payload_count + $urandom_range(1, 3);
                end
            end else if (variant == WAV_CUT_SHORT) begin
                payload_count = 0;
            end else begin
                payload_count = $urandom_range(0, 4);
            end
            for (int i = 0; i < payload_count; i++) begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cycle_count <= '0;
            hold_off <= 1'b0;
        end else begin
            cycle_count <= cycle_count + 1;
            hold_off <= (cycle_count >= HOLD_START) && (cycle_count < HOLD_START + HOLD_CYCLES);
        end
    end

    assign tx_steady = (cycle_count[10:8] == 3'd2) || (cycle_count[10:8] == 3'd3) || hold_off;
    assign rx_steady = (cycle_count[10:8] == 3'd3) || (cycle_count[10:8] == 3'd6);

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tuser);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_byte.value;
                    s_tuser <= next_byte.first;
                    tx_wait = draw_wait(tx_steady);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("beat of kind %0d with nothing expected", m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(m_tuser), 32'(want.kind));
                    check_field("error_code", 32'(m_tdata[1:0]), 32'(want.error_code));
                    check_field("audio_format", 32'(m_tdata[4:2]), 32'(want.audio_format));
                    check_field("sample_rate", m_tdata[36:5], want.sample_rate);
                    check_field("payload_size", m_tdata[68:37], want.payload_size);
                    check_field("payload_byte", 32'(m_tdata[76:69]), 32'(want.payload_byte));
                    check_field("last", 32'(m_tlast), 32'(want.last));
                end
                rx_wait = draw_wait(rx_steady);
            end
            if (hold_off || rx_wait > 0) begin
                m_tready <= 1'b0;
                if (!hold_off) begin
                    rx_wait--;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // Stray bytes while idle, a damaged RIFF tag, and restarts in the middle of a header.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h52, 1'b1);
        push_byte(8'h49, 1'b0);
        push_byte(8'h46, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h52, 1'b1);
        push_byte(8'h49, 1'b0);
        push_byte(8'h52, 1'b1);
        push_byte(8'h49, 1'b0);
        push_byte(8'h46, 1'b0);
        push_byte(8'h46, 1'b0);

        add_file(WAV_GOOD, 1'b1);
        for (int v = WAV_BAD_RIFF; v <= WAV_CUT_SHORT; v++) begin
            add_file(wav_variant_t'(v), 1'b0);
        end
        while (pending_bytes.size() < ITEM_TARGET) begin
            case ($urandom_range(0, 19)) inside
                [0:11]:  add_file(WAV_GOOD, 1'b0);
                [12:17]: add_file(wav_variant_t'($urandom_range(1, 6)), 1'b0);
                default: add_file(WAV_CUT_SHORT, 1'b0);
            endcase
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        @(posedge aclk);
        while (!aresetn || pending_bytes.size() != 0 || s_tvalid
               || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
